@@ rtl/core/skt_pkg.sv @@
// ----------------------------------------------------------------------------
// skt_pkg
// Shared types and codes for the sorted key table.
// ----------------------------------------------------------------------------
`default_nettype none

package skt_pkg;

  localparam int unsigned KeyW   = 16;
  localparam int unsigned PayW   = 16;
  localparam int unsigned OpW    = 2;
  localparam int unsigned StatW  = 2;
  localparam int unsigned PosW   = 6;
  localparam int unsigned CountW = 7;

  typedef enum logic [OpW-1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_LOOKUP = 2'd2
  } op_e;

  typedef enum logic [StatW-1:0] {
    ST_DONE      = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2
  } status_e;

  typedef struct packed {
    logic [KeyW-1:0] key;
    logic [PayW-1:0] payload;
  } entry_t;

endpackage

`default_nettype wire

@@ rtl/core/skt_ram.sv @@
// ----------------------------------------------------------------------------
// skt_ram
// Entry storage: one write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module skt_ram import skt_pkg::*; #(
  parameter int unsigned Depth = 64,
  parameter int unsigned AddrW = 6
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire entry_t           wdata_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output entry_t                rdata_o
);

  entry_t mem [Depth];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // reads past the fill point return whatever is there and are never used
  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

@@ rtl/core/sorted_key_table.sv @@
// ----------------------------------------------------------------------------
// sorted_key_table
// Sorted table of key/payload entries with insert, remove and lookup.
// Insert shifts larger entries up from the end, lookup scans up from position
// zero, remove scans and then closes the gap; a full table or unused opcode
// goes straight to the response, held in a result register. The single table
// memory is walked one entry per cycle; transactions are taken one at a time.
// Reset empties the table (count to zero); entry storage is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_key_table import skt_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = 64
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire logic [OpW-1:0]    opcode_i,
  input  wire logic [KeyW-1:0]   key_i,
  input  wire logic [PayW-1:0]   payload_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output logic [StatW-1:0]       status_o,
  output logic [PosW-1:0]        position_o,
  output logic [PayW-1:0]        found_payload_o,
  output logic [CountW-1:0]      entry_count_o
);

  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SHIFT = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_CLOSE = 3'd3;
  localparam logic [2:0] S_RESP  = 3'd4;

  logic [2:0]      state_q, state_d;
  logic [CW-1:0]   idx_q, idx_d;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic [OpW-1:0]  op_q;
  logic [KeyW-1:0] key_q;
  logic [PayW-1:0] pay_q;

  logic [StatW-1:0] res_status_q, res_status_d;
  logic [PosW-1:0]  res_pos_q, res_pos_d;
  logic [PayW-1:0]  res_pay_q, res_pay_d;

  logic              out_valid_q, out_valid_d;
  logic [StatW-1:0]  out_status_q;
  logic [PosW-1:0]   out_pos_q;
  logic [PayW-1:0]   out_pay_q;
  logic [CountW-1:0] out_cnt_q;

  logic    accept;
  logic    load_out;
  logic    we;
  logic [AW-1:0] waddr;
  logic [AW-1:0] raddr;
  entry_t  wdata;
  entry_t  rdata;

  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && !in_stall_o;

  skt_ram #(
    .Depth (TABLE_DEPTH),
    .AddrW (AW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_comb begin
    state_d      = state_q;
    idx_d        = idx_q;
    cnt_d        = cnt_q;
    res_status_d = res_status_q;
    res_pos_d    = res_pos_q;
    res_pay_d    = res_pay_q;
    we           = 1'b0;
    waddr        = idx_q[AW-1:0];
    wdata        = '{key: key_q, payload: pay_q};
    load_out     = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          res_status_d = ST_DONE;
          res_pos_d    = '0;
          res_pay_d    = '0;
          unique case (opcode_i)
            OP_INSERT: begin
              if (cnt_q == CW'(TABLE_DEPTH)) begin
                res_status_d = ST_FULL;
                state_d      = S_RESP;
              end else begin
                idx_d   = cnt_q;
                state_d = S_SHIFT;
              end
            end
            OP_REMOVE, OP_LOOKUP: begin
              idx_d   = '0;
              state_d = S_SCAN;
            end
            default: begin
              state_d = S_RESP;
            end
          endcase
        end
      end

      // rdata holds the entry just below idx_q
      S_SHIFT: begin
        we = 1'b1;
        if (idx_q != '0 && rdata.key > key_q) begin
          wdata = rdata;
          idx_d = idx_q - 1'b1;
        end else begin
          res_pos_d = PosW'(idx_q);
          cnt_d     = cnt_q + 1'b1;
          state_d   = S_RESP;
        end
      end

      // rdata holds the entry at idx_q
      S_SCAN: begin
        if (idx_q == cnt_q) begin
          res_status_d = ST_NOT_FOUND;
          state_d      = S_RESP;
        end else if (rdata.key == key_q) begin
          res_pos_d = PosW'(idx_q);
          res_pay_d = rdata.payload;
          state_d   = (op_q == OP_REMOVE) ? S_CLOSE : S_RESP;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end

      // rdata holds the entry just above idx_q
      S_CLOSE: begin
        if (CW'(idx_q + 1'b1) < cnt_q) begin
          we    = 1'b1;
          wdata = rdata;
          idx_d = idx_q + 1'b1;
        end else begin
          cnt_d   = cnt_q - 1'b1;
          state_d = S_RESP;
        end
      end

      S_RESP: begin
        if (!out_valid_q || !out_stall_i) begin
          load_out = 1'b1;
          state_d  = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // read one entry ahead of the walk so data is ready on the next cycle
  always_comb begin
    unique case (state_d)
      S_SHIFT: raddr = AW'(idx_d - 1'b1);
      S_CLOSE: raddr = AW'(idx_d + 1'b1);
      default: raddr = idx_d[AW-1:0];
    endcase
  end

  assign out_valid_d = load_out || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      idx_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q  <= opcode_i;
      key_q <= key_i;
      pay_q <= payload_i;
    end
    res_status_q <= res_status_d;
    res_pos_q    <= res_pos_d;
    res_pay_q    <= res_pay_d;
    if (load_out) begin
      out_status_q <= res_status_q;
      out_pos_q    <= res_pos_q;
      out_pay_q    <= res_pay_q;
      out_cnt_q    <= CountW'(cnt_q);
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = out_status_q;
  assign position_o      = out_pos_q;
  assign found_payload_o = out_pay_q;
  assign entry_count_o   = out_cnt_q;

endmodule

`default_nettype wire
